/* hw/rtl/glob_pattern_matcher_core_defines.svh */
// Assertion shorthands for the glob matcher, clocked on aclk and
// quiet while aresetn is low.
`ifndef GLOB_PATTERN_MATCHER_CORE_DEFINES_SVH
`define GLOB_PATTERN_MATCHER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gpm_pkg.sv */
package gpm_pkg;

    localparam int PATTERN_LEN = 32;
    localparam int LEN_W       = $clog2(PATTERN_LEN + 1);
    localparam int POS_W       = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
    // A closed class takes at least two bytes.
    localparam int CLS_NUM     = (PATTERN_LEN + 1) / 2;
    localparam int CLS_W       = (CLS_NUM > 1) ? $clog2(CLS_NUM) : 1;

    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_OPEN  = 8'h5B;
    localparam logic [7:0] CHR_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } gpm_op_t;

    // Role of one stored pattern byte, decided when it is appended.
    typedef struct packed {
        logic             is_star;
        logic             is_dot;
        logic             is_open;
        logic             is_close;
        logic             is_inner;
        logic [CLS_W-1:0] cls_id;
    } gpm_kind_t;

    function automatic logic [7:0] gpm_fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/glob_pattern_matcher_core.sv */
// Case-insensitive glob matcher. The tuser field selects the transaction kind:
// clear the pattern, append one pattern byte (tdata), feed one text byte
// (tdata) or mark end of text. Only end of text yields a result, carrying
// whether the whole line matched and whether a pattern append was dropped
// since the last clear. The pattern holds up to 32 bytes; '*' matches any run,
// '.' any one byte, and '[..]' one listed byte, closed by the first ']'.
// Any append or clear restarts the current line. One transaction is taken
// every cycle unless an end-of-text one is held; each passes an input register
// and is applied to the match state from there, and m_tvalid is set as its
// end-of-text transaction is applied. An end-of-text transaction waits in the
// input register only while the result register is full and not being taken.
`include "glob_pattern_matcher_core_defines.svh"

module glob_pattern_matcher_core
    import gpm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    // input register
    logic            stg_valid_reg, stg_valid_next;
    gpm_op_t         stg_op_reg;
    logic [7:0]      stg_byte_reg;
    logic            stg_go;

    // pattern and match state
    logic [7:0]        pat_chr_reg  [PATTERN_LEN];
    gpm_kind_t         pat_kind_reg [PATTERN_LEN];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              inside_reg, inside_next;
    logic [CLS_W-1:0]  cls_cnt_reg, cls_cnt_next;
    logic [PATTERN_LEN:0] seed_reg, seed_next;

    // result register
    logic m_tvalid_reg, m_tvalid_next;
    logic m_matched_reg, m_ovf_reg;

    // combinational terms
    logic [PATTERN_LEN-1:0] pos_vld;
    logic [PATTERN_LEN-1:0] hit;
    logic [PATTERN_LEN:0]   act;
    logic [PATTERN_LEN:0]   seed_txt;
    logic [CLS_NUM-1:0]     cls_arm, cls_hit, cls_fire;
    logic [7:0]             fold_byte;
    gpm_kind_t              new_kind;
    logic                   can_store;

    assign stg_go   = stg_valid_reg &&
                      (stg_op_reg != OP_END || !m_tvalid_reg || m_tready);
    assign s_tready = !stg_valid_reg || stg_go;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_matched_reg};

    assign fold_byte = gpm_fold(stg_byte_reg);
    assign can_store = (len_reg < LEN_W'(PATTERN_LEN));

    always_comb begin
        for (int i = 0; i < PATTERN_LEN; i++) begin
            pos_vld[i] = (LEN_W'(i) < len_reg);
            hit[i]     = (pat_chr_reg[i] == fold_byte);
        end
    end

    // Active set: stored seeds, carried across runs of stars.
    always_comb begin
        act[0] = seed_reg[0];
        for (int k = 1; k <= PATTERN_LEN; k++) begin
            act[k] = seed_reg[k] |
                     (act[k-1] & pos_vld[k-1] & pat_kind_reg[k-1].is_star);
        end
    end

    // Classes: armed by an active '[', hit by any listed byte.
    always_comb begin
        for (int c = 0; c < CLS_NUM; c++) begin
            cls_arm[c] = 1'b0;
            cls_hit[c] = 1'b0;
            for (int i = 0; i < PATTERN_LEN; i++) begin
                if (pos_vld[i] && pat_kind_reg[i].cls_id == CLS_W'(c)) begin
                    if (pat_kind_reg[i].is_open && act[i]) begin
                        cls_arm[c] = 1'b1;
                    end
                    if (pat_kind_reg[i].is_inner && hit[i]) begin
                        cls_hit[c] = 1'b1;
                    end
                end
            end
            cls_fire[c] = cls_arm[c] & cls_hit[c];
        end
    end

    always_comb begin
        seed_txt = '0;
        for (int i = 0; i < PATTERN_LEN; i++) begin
            if (pos_vld[i]) begin
                if (act[i] && pat_kind_reg[i].is_star) begin
                    seed_txt[i] = 1'b1;
                end
                if (act[i] && !pat_kind_reg[i].is_star && !pat_kind_reg[i].is_open &&
                    (pat_kind_reg[i].is_dot || hit[i])) begin
                    seed_txt[i+1] = 1'b1;
                end
                if (pat_kind_reg[i].is_close && cls_fire[pat_kind_reg[i].cls_id]) begin
                    seed_txt[i+1] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        new_kind.is_open  = !inside_reg && (fold_byte == CHR_OPEN);
        new_kind.is_close = inside_reg && (fold_byte == CHR_CLOSE);
        new_kind.is_inner = inside_reg && (fold_byte != CHR_CLOSE);
        new_kind.is_star  = !inside_reg && (fold_byte == CHR_STAR);
        new_kind.is_dot   = !inside_reg && (fold_byte == CHR_DOT);
        new_kind.cls_id   = cls_cnt_reg;
    end

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_tready) begin
            stg_valid_next = s_tvalid;
        end

        len_next      = len_reg;
        ovf_next      = ovf_reg;
        inside_next   = inside_reg;
        cls_cnt_next  = cls_cnt_reg;
        seed_next     = seed_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        if (stg_go) begin
            case (stg_op_reg)
                OP_CLEAR: begin
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    inside_next  = 1'b0;
                    cls_cnt_next = '0;
                    seed_next    = (PATTERN_LEN + 1)'(1);
                end
                OP_APPEND: begin
                    if (can_store) begin
                        len_next = len_reg + LEN_W'(1);
                        if (new_kind.is_open) begin
                            inside_next = 1'b1;
                        end
                        if (new_kind.is_close) begin
                            inside_next  = 1'b0;
                            cls_cnt_next = cls_cnt_reg + CLS_W'(1);
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    seed_next = (PATTERN_LEN + 1)'(1);
                end
                OP_TEXT: begin
                    seed_next = seed_txt;
                end
                OP_END: begin
                    m_tvalid_next = 1'b1;
                    seed_next     = (PATTERN_LEN + 1)'(1);
                end
                default: begin
                    seed_next = seed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            inside_reg    <= 1'b0;
            cls_cnt_reg   <= '0;
            seed_reg      <= (PATTERN_LEN + 1)'(1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            inside_reg    <= inside_next;
            cls_cnt_reg   <= cls_cnt_next;
            seed_reg      <= seed_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            stg_op_reg   <= gpm_op_t'(s_tuser);
            stg_byte_reg <= s_tdata;
        end
        if (stg_go && stg_op_reg == OP_APPEND && can_store) begin
            pat_chr_reg[len_reg[POS_W-1:0]]  <= fold_byte;
            pat_kind_reg[len_reg[POS_W-1:0]] <= new_kind;
        end
        if (stg_go && stg_op_reg == OP_END) begin
            m_matched_reg <= act[len_reg];
            m_ovf_reg     <= ovf_reg;
        end
    end

    `GPM_ASSERT_NEXT(a_clear_empties, stg_go && stg_op_reg == OP_CLEAR, len_reg == '0 && !ovf_reg, "clear left pattern state behind")
    `GPM_ASSERT_SAME(a_ovf_cause, $rose(ovf_reg), $past(stg_go && stg_op_reg == OP_APPEND && len_reg == LEN_W'(PATTERN_LEN)), "overflow without a dropped append")
    `GPM_ASSERT_SAME(a_result_cause, $rose(m_tvalid_reg), $past(stg_go && stg_op_reg == OP_END), "result without end of text")
    `GPM_ASSERT_NEXT(a_text_keeps_len, stg_go && stg_op_reg == OP_TEXT, $stable(len_reg), "text byte changed pattern length")

endmodule
